// ----- sv/pfde_pkg.sv -----
// Package for the Playfair digraph encryptor.
// Holds the request codes, letter constants, controller states and the
// small letter and square helper functions. Depends on nothing.
`default_nettype none

package pfde_pkg;

    localparam int unsigned NUM_LETTERS = 26;
    localparam int unsigned SQ_CELLS    = 25;

    localparam logic [4:0] LETTER_I    = 5'd8;
    localparam logic [4:0] LETTER_J    = 5'd9;
    localparam logic [4:0] LETTER_X    = 5'd23;
    localparam logic [4:0] LAST_LETTER = 5'd25;
    localparam logic [4:0] CELL_COUNT  = 5'd25;

    localparam logic [7:0] ASCII_UP_A = 8'h41;
    localparam logic [7:0] ASCII_UP_Z = 8'h5A;
    localparam logic [7:0] ASCII_LO_A = 8'h61;
    localparam logic [7:0] ASCII_LO_Z = 8'h7A;
    localparam logic [7:0] CASE_DELTA = 8'h20;
    localparam logic [6:0] FILLER_RESET = 7'h58;

    localparam logic [2:0] ACT_NEW_KEY  = 3'd0;
    localparam logic [2:0] ACT_KEY_BYTE = 3'd1;
    localparam logic [2:0] ACT_FINISH   = 3'd2;
    localparam logic [2:0] ACT_TEXT     = 3'd3;
    localparam logic [2:0] ACT_END      = 3'd4;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_FINISH,
        ST_CELL_A,
        ST_CELL_B,
        ST_SQ_A,
        ST_SQ_B,
        ST_OUT1,
        ST_OUT2
    } pfde_state_t;

    typedef struct packed {
        logic       valid;
        logic [4:0] idx;
    } letter_t;

    // Upper-cases a byte, folds J into I and reports whether it is a letter.
    function automatic letter_t letter_index(input logic [7:0] b);
        letter_t    r;
        logic [7:0] u;
        logic [7:0] off;
        u = b;
        if (b >= ASCII_LO_A && b <= ASCII_LO_Z)
        begin
            u = b - CASE_DELTA;
        end
        off     = u - ASCII_UP_A;
        r.valid = (u >= ASCII_UP_A) && (u <= ASCII_UP_Z);
        r.idx   = off[4:0];
        if (r.idx == LETTER_J)
        begin
            r.idx = LETTER_I;
        end
        return r;
    endfunction

    // Row of a square cell 0..24.
    function automatic logic [2:0] cell_row(input logic [4:0] c);
        logic [2:0] r;
        if (c >= 5'd20)
        begin
            r = 3'd4;
        end
        else if (c >= 5'd15)
        begin
            r = 3'd3;
        end
        else if (c >= 5'd10)
        begin
            r = 3'd2;
        end
        else if (c >= 5'd5)
        begin
            r = 3'd1;
        end
        else
        begin
            r = 3'd0;
        end
        return r;
    endfunction

    // Column of a square cell 0..24.
    function automatic logic [2:0] cell_col(input logic [4:0] c);
        logic [4:0] base;
        logic [4:0] d;
        base = {2'b00, cell_row(c)} * 5'd5;
        d    = c - base;
        return d[2:0];
    endfunction

    // Step one place along a row or column, wrapping after the fifth.
    function automatic logic [2:0] wrap_inc(input logic [2:0] x);
        return (x == 3'd4) ? 3'd0 : x + 3'd1;
    endfunction

    function automatic logic [4:0] cell_at(input logic [2:0] r, input logic [2:0] c);
        return ({2'b00, r} * 5'd5) + {2'b00, c};
    endfunction

endpackage

`default_nettype wire

// ----- sv/pfde_ifs.sv -----
// Valid/ready channel interfaces of the Playfair digraph encryptor.
// The request channel carries action codes and raw bytes; the result
// channel carries cipher letters. Depends on nothing.
`default_nettype none

interface pfde_req_if;
    logic       valid;
    logic       ready;
    logic [2:0] action;
    logic [7:0] char_in;

    modport source (output valid, output action, output char_in, input ready);
    modport sink (input valid, input action, input char_in, output ready);
endinterface

interface pfde_rsp_if;
    logic       valid;
    logic       ready;
    logic [6:0] cipher_letter;
    logic       pair_end;
    logic       message_end;

    modport source (output valid, output cipher_letter, output pair_end,
                    output message_end, input ready);
    modport sink (input valid, input cipher_letter, input pair_end,
                  input message_end, output ready);
endinterface

`default_nettype wire

// ----- sv/pfde_ram.sv -----
// Generic single-write, single-read synchronous RAM with registered read.
// Used for the key square and the letter-to-cell table. No dependencies.
`default_nettype none

module pfde_ram #(
    parameter int DATA_W = 8,
    parameter int DEPTH  = 32
) (
    input  wire logic                       clk,
    input  wire logic                       wr_en,
    input  wire logic [$clog2(DEPTH)-1:0]   wr_addr,
    input  wire logic [DATA_W-1:0]          wr_data,
    input  wire logic                       rd_en,
    input  wire logic [$clog2(DEPTH)-1:0]   rd_addr,
    output      logic [DATA_W-1:0]          rd_data
);

    logic [DATA_W-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

// ----- sv/playfair_digraph_encrypt.sv -----
// Top level of the streaming Playfair digraph encryptor.
// Depends on pfde_pkg, the channel interfaces in pfde_ifs.sv and pfde_ram.
//
//  Channel   Direction  Handshake      Payload
//  req       in         valid/ready    action[2:0], char_in[7:0]
//  rsp       out        valid/ready    cipher_letter[6:0], pair_end, message_end
//  cfg       in         cfg_we only    cfg_wdata[6:0] (filler letter)
//
// A request that produces no letters (new key, key byte, a held text letter,
// anything dropped) is handled in ST_IDLE alone. Finishing the key sweeps the
// 26 letter codes one a cycle into the square, J skipped, limited by the single
// write port of each table. A request that completes a pair runs two reads of
// the cell table and two reads of the key square on their one read port, then
// one cipher letter per output state, each held while the result is stalled.
// Reset clears the control state and the seen flags; the two tables hold
// garbage until the key is built. One request is in flight at a time, so
// the request side waits while a result letter is stalled.
`default_nettype none

module playfair_digraph_encrypt
    import pfde_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       cfg_we,
    input  wire logic [6:0] cfg_wdata,
    pfde_req_if.sink        req,
    pfde_rsp_if.source      rsp
);

    // Control state.
    pfde_state_t state_reg, state_next;
    logic [6:0]  filler_reg;
    logic [25:0] seen_reg, seen_next;
    logic [4:0]  fill_reg, fill_next;
    logic        key_ready_reg, key_ready_next;
    logic [4:0]  held_reg, held_next;
    logic        held_valid_reg, held_valid_next;
    logic [4:0]  sweep_reg, sweep_next;

    // Pair payload, carried through the lookup sequence.
    logic [4:0]  a_reg, a_next;
    logic [4:0]  b_reg, b_next;
    logic        fin_reg, fin_next;
    logic [4:0]  ca_reg;
    logic [4:0]  o2_reg;
    logic [4:0]  l1_reg;

    logic        req_take;
    letter_t     in_letter;
    letter_t     fill_letter;
    logic [4:0]  filler_idx;

    logic        place_en;
    logic [4:0]  place_idx;
    logic        place_wr;

    logic [4:0]  cell_rd_addr;
    logic [4:0]  cell_rd_data;
    logic        cell_rd_en;
    logic [4:0]  sq_rd_addr;
    logic [4:0]  sq_rd_data;
    logic        sq_rd_en;

    logic [2:0]  r1, c1, r2, c2;
    logic [4:0]  o1, o2;

    assign req.ready   = (state_reg == ST_IDLE);
    assign req_take    = req.valid && req.ready;
    assign in_letter   = letter_index(req.char_in);
    assign fill_letter = letter_index({1'b0, filler_reg});
    // A filler that is not a letter falls back to X.
    assign filler_idx  = fill_letter.valid ? fill_letter.idx : LETTER_X;

    // A letter is placed only once and only while the square has room.
    always_comb
    begin
        place_en  = 1'b0;
        place_idx = in_letter.idx;
        if (state_reg == ST_FINISH)
        begin
            place_idx = sweep_reg;
            place_en  = (sweep_reg != LETTER_J);
        end
        else if (req_take && req.action == ACT_KEY_BYTE)
        begin
            place_en = !key_ready_reg && in_letter.valid;
        end
    end

    assign place_wr = place_en && !seen_reg[place_idx] && (fill_reg < CELL_COUNT);

    // Both tables are written together: the square maps cell to letter and
    // the cell table maps letter back to cell. Writes happen only while the
    // key is being built and reads only after it is finished, so the two
    // never touch the same entry in the same cycle.
    pfde_ram #(
        .DATA_W (5),
        .DEPTH  (25)
    ) u_key_square (
        .clk     (clk),
        .wr_en   (place_wr),
        .wr_addr (fill_reg),
        .wr_data (place_idx),
        .rd_en   (sq_rd_en),
        .rd_addr (sq_rd_addr),
        .rd_data (sq_rd_data)
    );

    pfde_ram #(
        .DATA_W (5),
        .DEPTH  (26)
    ) u_letter_cell (
        .clk     (clk),
        .wr_en   (place_wr),
        .wr_addr (place_idx),
        .wr_data (fill_reg),
        .rd_en   (cell_rd_en),
        .rd_addr (cell_rd_addr),
        .rd_data (cell_rd_data)
    );

    // The cell of the first letter is latched in ST_CELL_B; the cell of the
    // second letter arrives from the table in ST_SQ_A, where the Playfair
    // rule picks the two output cells.
    always_comb
    begin
        r1 = cell_row(ca_reg);
        c1 = cell_col(ca_reg);
        r2 = cell_row(cell_rd_data);
        c2 = cell_col(cell_rd_data);
        if (r1 == r2)
        begin
            o1 = cell_at(r1, wrap_inc(c1));
            o2 = cell_at(r2, wrap_inc(c2));
        end
        else if (c1 == c2)
        begin
            o1 = cell_at(wrap_inc(r1), c1);
            o2 = cell_at(wrap_inc(r2), c2);
        end
        else
        begin
            o1 = cell_at(r1, c2);
            o2 = cell_at(r2, c1);
        end
    end

    assign cell_rd_en   = (state_reg == ST_CELL_A) || (state_reg == ST_CELL_B);
    assign cell_rd_addr = (state_reg == ST_CELL_A) ? a_reg : b_reg;
    // The second square read is left in the RAM output register, which then
    // holds the second cipher letter through both output states.
    assign sq_rd_en     = (state_reg == ST_SQ_A) || (state_reg == ST_SQ_B);
    assign sq_rd_addr   = (state_reg == ST_SQ_A) ? o1 : o2_reg;

    assign rsp.valid         = (state_reg == ST_OUT1) || (state_reg == ST_OUT2);
    assign rsp.cipher_letter = (state_reg == ST_OUT2)
                             ? 7'(ASCII_UP_A) + {2'b00, sq_rd_data}
                             : 7'(ASCII_UP_A) + {2'b00, l1_reg};
    assign rsp.pair_end      = (state_reg == ST_OUT2);
    assign rsp.message_end   = (state_reg == ST_OUT2) && fin_reg;

    // Next state and request handling.
    always_comb
    begin
        state_next      = state_reg;
        seen_next       = seen_reg;
        fill_next       = fill_reg;
        key_ready_next  = key_ready_reg;
        held_next       = held_reg;
        held_valid_next = held_valid_reg;
        sweep_next      = sweep_reg;
        a_next          = a_reg;
        b_next          = b_reg;
        fin_next        = fin_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (req_take)
                begin
                    case (req.action)
                        ACT_NEW_KEY:
                        begin
                            seen_next       = '0;
                            fill_next       = 5'd0;
                            key_ready_next  = 1'b0;
                            held_valid_next = 1'b0;
                        end
                        ACT_FINISH:
                        begin
                            if (!key_ready_reg)
                            begin
                                sweep_next = 5'd0;
                                state_next = ST_FINISH;
                            end
                        end
                        ACT_TEXT:
                        begin
                            if (key_ready_reg && in_letter.valid)
                            begin
                                if (!held_valid_reg)
                                begin
                                    held_next       = in_letter.idx;
                                    held_valid_next = 1'b1;
                                end
                                else
                                begin
                                    a_next     = held_reg;
                                    fin_next   = 1'b0;
                                    state_next = ST_CELL_A;
                                    if (in_letter.idx == held_reg)
                                    begin
                                        // Doubled letter: filler goes in, the
                                        // repeat opens the next pair.
                                        b_next = filler_idx;
                                    end
                                    else
                                    begin
                                        b_next          = in_letter.idx;
                                        held_valid_next = 1'b0;
                                    end
                                end
                            end
                        end
                        ACT_END:
                        begin
                            if (key_ready_reg && held_valid_reg)
                            begin
                                a_next          = held_reg;
                                b_next          = filler_idx;
                                fin_next        = 1'b1;
                                held_valid_next = 1'b0;
                                state_next      = ST_CELL_A;
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            ST_FINISH:
            begin
                if (sweep_reg == LAST_LETTER)
                begin
                    key_ready_next  = 1'b1;
                    held_valid_next = 1'b0;
                    state_next      = ST_IDLE;
                end
                else
                begin
                    sweep_next = sweep_reg + 5'd1;
                end
            end
            ST_CELL_A: state_next = ST_CELL_B;
            ST_CELL_B: state_next = ST_SQ_A;
            ST_SQ_A:   state_next = ST_SQ_B;
            ST_SQ_B:   state_next = ST_OUT1;
            ST_OUT1:
            begin
                if (rsp.ready)
                begin
                    state_next = ST_OUT2;
                end
            end
            ST_OUT2:
            begin
                if (rsp.ready)
                begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase

        if (place_wr)
        begin
            seen_next[place_idx] = 1'b1;
            fill_next            = fill_reg + 5'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            filler_reg     <= FILLER_RESET;
            seen_reg       <= '0;
            fill_reg       <= 5'd0;
            key_ready_reg  <= 1'b0;
            held_reg       <= 5'd0;
            held_valid_reg <= 1'b0;
            sweep_reg      <= 5'd0;
        end
        else
        begin
            state_reg      <= state_next;
            seen_reg       <= seen_next;
            fill_reg       <= fill_next;
            key_ready_reg  <= key_ready_next;
            held_reg       <= held_next;
            held_valid_reg <= held_valid_next;
            sweep_reg      <= sweep_next;
            if (cfg_we)
            begin
                filler_reg <= cfg_wdata;
            end
        end
    end

    // Pair payload needs no reset.
    always_ff @(posedge clk)
    begin
        a_reg   <= a_next;
        b_reg   <= b_next;
        fin_reg <= fin_next;
        if (state_reg == ST_CELL_B)
        begin
            ca_reg <= cell_rd_data;
        end
        if (state_reg == ST_SQ_A)
        begin
            o2_reg <= o2;
        end
        if (state_reg == ST_SQ_B)
        begin
            l1_reg <= sq_rd_data;
        end
    end

endmodule

`default_nettype wire

// ----- dv/pfde_tb_pkg.sv -----
// Scoreboard for the Playfair digraph encryptor testbench.
// Predicts cipher letters from accepted requests and checks each result letter.
// Depends on pfde_pkg for the request codes and letter constants.
`timescale 1ns / 1ps

package pfde_tb_pkg;

    import pfde_pkg::*;

    typedef struct {
        bit [6:0] letter;
        bit       pair_end;
        bit       message_end;
    } cipher_out_t;

    class cipher_scoreboard;

        bit [6:0]    filler;
        bit [4:0]    square [SQ_CELLS];
        bit [4:0]    cell_of [NUM_LETTERS];
        bit          seen [NUM_LETTERS];
        int unsigned placed;
        bit          key_done;
        bit [4:0]    held;
        bit          held_ok;
        cipher_out_t expected_letters [$];
        int unsigned errors;

        function new();
            filler   = FILLER_RESET;
            placed   = 0;
            key_done = 1'b0;
            held     = '0;
            held_ok  = 1'b0;
            errors   = 0;
            foreach (seen[i])
            begin
                seen[i] = 1'b0;
            end
        endfunction

        // Letter number 0..25 with J folded into I, or -1 for any other byte.
        function int fold_letter(bit [7:0] b);
            bit [7:0] u;
            int       k;
            u = b;
            if (b >= ASCII_LO_A && b <= ASCII_LO_Z)
            begin
                u = b - CASE_DELTA;
            end
            if (u < ASCII_UP_A || u > ASCII_UP_Z)
            begin
                return -1;
            end
            k = int'(u - ASCII_UP_A);
            if (k == LETTER_J)
            begin
                k = LETTER_I;
            end
            return k;
        endfunction

        function void place(int k);
            if (seen[k] || placed >= SQ_CELLS)
            begin
                return;
            end
            seen[k]         = 1'b1;
            square[placed]  = 5'(k);
            cell_of[k]      = 5'(placed);
            placed++;
        endfunction

        function int filler_code();
            int f;
            f = fold_letter({1'b0, filler});
            return (f < 0) ? LETTER_X : f;
        endfunction

        function void push_pair(int a, int b, bit last);
            int          ca, cb, r1, c1, r2, c2, o1, o2;
            cipher_out_t e;
            ca = cell_of[a];
            cb = cell_of[b];
            r1 = ca / 5;
            c1 = ca % 5;
            r2 = cb / 5;
            c2 = cb % 5;
            if (r1 == r2)
            begin
                o1 = r1 * 5 + (c1 + 1) % 5;
                o2 = r2 * 5 + (c2 + 1) % 5;
            end
            else if (c1 == c2)
            begin
                o1 = ((r1 + 1) % 5) * 5 + c1;
                o2 = ((r2 + 1) % 5) * 5 + c2;
            end
            else
            begin
                o1 = r1 * 5 + c2;
                o2 = r2 * 5 + c1;
            end
            e.letter      = 7'(ASCII_UP_A) + {2'b00, square[o1]};
            e.pair_end    = 1'b0;
            e.message_end = 1'b0;
            expected_letters.push_back(e);
            e.letter      = 7'(ASCII_UP_A) + {2'b00, square[o2]};
            e.pair_end    = 1'b1;
            e.message_end = last;
            expected_letters.push_back(e);
        endfunction

        function void note_request(bit [2:0] act, bit [7:0] ch);
            int k;
            case (act)
                ACT_NEW_KEY:
                begin
                    foreach (seen[i])
                    begin
                        seen[i] = 1'b0;
                    end
                    placed   = 0;
                    key_done = 1'b0;
                    held_ok  = 1'b0;
                end
                ACT_KEY_BYTE:
                begin
                    if (!key_done)
                    begin
                        k = fold_letter(ch);
                        if (k >= 0)
                        begin
                            place(k);
                        end
                    end
                end
                ACT_FINISH:
                begin
                    if (!key_done)
                    begin
                        for (int l = 0; l < NUM_LETTERS; l++)
                        begin
                            if (l != LETTER_J)
                            begin
                                place(l);
                            end
                        end
                        key_done = 1'b1;
                        held_ok  = 1'b0;
                    end
                end
                ACT_TEXT:
                begin
                    k = fold_letter(ch);
                    if (key_done && k >= 0)
                    begin
                        if (!held_ok)
                        begin
                            held    = 5'(k);
                            held_ok = 1'b1;
                        end
                        else if (k == held)
                        begin
                            push_pair(held, filler_code(), 1'b0);
                            held = 5'(k);
                        end
                        else
                        begin
                            push_pair(held, k, 1'b0);
                            held_ok = 1'b0;
                        end
                    end
                end
                ACT_END:
                begin
                    if (key_done && held_ok)
                    begin
                        push_pair(held, filler_code(), 1'b1);
                        held_ok = 1'b0;
                    end
                end
                default:
                begin
                end
            endcase
        endfunction

        function void check_letter(bit [6:0] letter, bit pe, bit me);
            cipher_out_t e;
            if (expected_letters.size() == 0)
            begin
                $error("unexpected cipher letter %h", letter);
                errors++;
                return;
            end
            e = expected_letters.pop_front();
            if (letter != e.letter)
            begin
                $error("cipher_letter: expected %h, got %h", e.letter, letter);
                errors++;
            end
            if (pe != e.pair_end)
            begin
                $error("pair_end: expected %0d, got %0d", e.pair_end, pe);
                errors++;
            end
            if (me != e.message_end)
            begin
                $error("message_end: expected %0d, got %0d", e.message_end, me);
                errors++;
            end
        endfunction

        function int pending();
            return expected_letters.size();
        endfunction

    endclass

endpackage

// ----- dv/tb_playfair_digraph_encrypt.sv -----
// Self-checking testbench for the streaming Playfair digraph encryptor.
// Drives key and text requests with random gaps and result stalls and checks
// every cipher letter against the scoreboard in pfde_tb_pkg (uses pfde_pkg).
`timescale 1ns / 1ps

module tb_playfair_digraph_encrypt;

    import pfde_pkg::*;
    import pfde_tb_pkg::*;

    // Cycles with no accepted request or result before the run is declared hung.
    // The slowest legal quiet stretch is a drain plus the settle time plus a key
    // finish.
    localparam int unsigned STALL_LIMIT = 2000;
    // Settle time before a filler write and at the end; covers the key finish,
    // which produces no letter.
    localparam int unsigned SETTLE_CYCLES = 40;
    localparam int unsigned WORK_ITEMS    = 1200;

    logic       clk;
    logic       rst_n;
    logic       cfg_we;
    logic [6:0] cfg_wdata;

    pfde_req_if req ();
    pfde_rsp_if rsp ();

    playfair_digraph_encrypt DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .req       (req),
        .rsp       (rsp)
    );

    cipher_scoreboard sb = new();

    // When set, neither side inserts gaps, so back-to-back traffic is covered.
    bit          quiet;
    int unsigned idle_cycles;
    int unsigned work_count;
    bit [4:0]    recent_letter;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Both channels are observed at the same edge. A request is noted before a
    // result is checked, although a result can never share an edge with the
    // request that caused it.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (req.valid && req.ready)
            begin
                sb.note_request(req.action, req.char_in);
            end
            if (rsp.valid && rsp.ready)
            begin
                sb.check_letter(rsp.cipher_letter, rsp.pair_end, rsp.message_end);
            end
            if ((req.valid && req.ready) || (rsp.valid && rsp.ready))
            begin
                idle_cycles <= 0;
            end
            else
            begin
                idle_cycles <= idle_cycles + 1;
            end
        end
    end

    // Hang detection. Polled on the falling edge so the count is settled.
    initial
    begin
        wait (rst_n === 1'b1);
        while (idle_cycles < STALL_LIMIT)
        begin
            @(negedge clk);
        end
        $display("*** FAILED ***");
        $finish;
    end

    // Result side: for every letter a random stall is drawn, none when quiet, then
    // ready is held high until the letter is taken. Ready stays high across
    // letters when the stall is zero, so it is never dropped and raised in the
    // same step.
    initial
    begin
        int unsigned stall;
        rsp.ready <= 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            stall = quiet ? 0 : $urandom_range(0, 11);
            if (stall > 0)
            begin
                rsp.ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            rsp.ready <= 1'b1;
            do
                @(posedge clk);
            while (!(rsp.valid && rsp.ready));
        end
    end

    // Sends one request after a random gap and returns at the edge where it is
    // accepted. Valid is left high so the next request can follow at once.
    task automatic send(input bit [2:0] act, input bit [7:0] ch);
        int unsigned gap;
        gap = quiet ? 0 : $urandom_range(0, 11);
        if (gap > 0)
        begin
            req.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req.valid   <= 1'b1;
        req.action  <= act;
        req.char_in <= ch;
        do
            @(posedge clk);
        while (!req.ready);
        work_count++;
    endtask

    // Holds the request side off until every predicted letter has arrived.
    task automatic drain();
        req.valid <= 1'b0;
        do
            @(negedge clk);
        while (sb.pending() != 0);
        @(posedge clk);
    endtask

    // The filler is only changed with the block idle. A key finish produces no
    // letter, so the settle time also lets a trailing finish run out.
    task automatic write_filler(input bit [6:0] v);
        drain();
        repeat (SETTLE_CYCLES) @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= v;
        @(posedge clk);
        cfg_we    <= 1'b0;
        sb.filler = v;
    endtask

    // A random letter in random case. Repeats of the previous letter and a
    // bias toward I, J and X make doubled letters and filler clashes common.
    function automatic bit [7:0] rand_letter();
        bit [4:0]    k;
        int unsigned pick;
        pick = $urandom_range(0, 9);
        if (pick < 2)
        begin
            k = recent_letter;
        end
        else if (pick < 4)
        begin
            case ($urandom_range(0, 2))
                0:       k = LETTER_I;
                1:       k = LETTER_J;
                default: k = LETTER_X;
            endcase
        end
        else
        begin
            k = 5'($urandom_range(0, 25));
        end
        recent_letter = k;
        return (ASCII_UP_A + 8'(k)) | (($urandom_range(0, 1) != 0) ? CASE_DELTA : 8'h00);
    endfunction

    // Key bytes are mostly letters with some arbitrary bytes mixed in.
    function automatic bit [7:0] rand_key_byte();
        if ($urandom_range(0, 5) == 0)
        begin
            return 8'($urandom_range(0, 255));
        end
        return rand_letter();
    endfunction

    initial
    begin
        bit [6:0]    fixed_fillers [8];
        bit [6:0]    fill_pick;
        int unsigned phase;
        int unsigned nkey;
        int unsigned ntext;
        int unsigned r;

        // Filler values cover both edges of the letter range, lower case, both
        // spellings of J and non-letters, so every filler bit takes both values.
        fixed_fillers = '{7'h41, 7'h5A, 7'h71, 7'h4A, 7'h00, 7'h7F, 7'h58, 7'h6A};
        quiet         = 1'b0;
        work_count    = 0;
        recent_letter = '0;
        idle_cycles   = 0;

        rst_n       <= 1'b0;
        cfg_we      <= 1'b0;
        cfg_wdata   <= '0;
        req.valid   <= 1'b0;
        req.action  <= ACT_NEW_KEY;
        req.char_in <= '0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part, with the filler at its reset value.
        // Text and end of message before any key must be dropped.
        send(ACT_TEXT, "A");
        send(ACT_END, 8'h00);
        // Key with mixed case, J folding into I, a repeat, punctuation and
        // bytes above the ASCII range.
        send(ACT_NEW_KEY, 8'h00);
        send(ACT_KEY_BYTE, "p");
        send(ACT_KEY_BYTE, "L");
        send(ACT_KEY_BYTE, "a");
        send(ACT_KEY_BYTE, "y");
        send(ACT_KEY_BYTE, "J");
        send(ACT_KEY_BYTE, "i");
        send(ACT_KEY_BYTE, "!");
        send(ACT_KEY_BYTE, 8'hC1);
        send(ACT_KEY_BYTE, 8'hFF);
        send(ACT_FINISH, 8'h00);
        // A second finish and a late key byte are both ignored.
        send(ACT_FINISH, 8'hFF);
        send(ACT_KEY_BYTE, "Z");
        // H/J pair, then a doubled E that needs the filler, then the repeated E paired
        // with x, then X held and padded with the X filler at end of message.
        send(ACT_TEXT, "h");
        send(ACT_TEXT, "J");
        send(ACT_TEXT, "e");
        send(ACT_TEXT, "E");
        send(ACT_TEXT, "x");
        send(ACT_TEXT, 8'h00);
        send(ACT_TEXT, "X");
        send(ACT_END, 8'h00);
        // End with nothing held, and the unused action codes.
        send(ACT_END, 8'hFF);
        send(3'd5, "A");
        send(3'd7, 8'hFF);
        send(ACT_TEXT, "z");
        send(ACT_END, 8'h00);

        // Random part: each phase sets a filler, builds a key and encrypts a
        // stream of text with broken sequences and noise mixed in.
        phase = 0;
        while (work_count < WORK_ITEMS)
        begin
            if (phase < 8)
            begin
                fill_pick = fixed_fillers[phase];
            end
            else if ($urandom_range(0, 2) == 0)
            begin
                fill_pick = 7'($urandom_range(0, 127));
            end
            else
            begin
                fill_pick = 7'($urandom_range(65, 90));
            end
            write_filler(fill_pick);
            phase++;
            quiet = ($urandom_range(0, 3) == 0);

            send(ACT_NEW_KEY, 8'($urandom_range(0, 255)));
            nkey = $urandom_range(0, 30);
            repeat (nkey)
            begin
                send(ACT_KEY_BYTE, rand_key_byte());
            end
            send(ACT_FINISH, 8'($urandom_range(0, 255)));

            ntext = $urandom_range(10, 80);
            repeat (ntext)
            begin
                r = $urandom_range(0, 99);
                if (r < 78)
                begin
                    send(ACT_TEXT, rand_letter());
                end
                else if (r < 85)
                begin
                    send(ACT_END, 8'($urandom_range(0, 255)));
                end
                else if (r < 90)
                begin
                    // Arbitrary byte; most are non-letters and get dropped.
                    send(ACT_TEXT, 8'($urandom_range(0, 255)));
                end
                else if (r < 92)
                begin
                    send(3'($urandom_range(5, 7)), 8'($urandom_range(0, 255)));
                end
                else if (r < 94)
                begin
                    // Key traffic after the key is finished is ignored.
                    send(ACT_KEY_BYTE, rand_key_byte());
                    send(ACT_FINISH, 8'($urandom_range(0, 255)));
                end
                else if (r < 95)
                begin
                    drain();
                end
                else if (r < 97)
                begin
                    quiet = ~quiet;
                end
                else
                begin
                    // Restart the key mid-message: the held letter is lost and
                    // text is dropped until the new key is finished.
                    send(ACT_NEW_KEY, 8'($urandom_range(0, 255)));
                    send(ACT_TEXT, rand_letter());
                    send(ACT_END, 8'($urandom_range(0, 255)));
                    nkey = $urandom_range(0, 8);
                    repeat (nkey)
                    begin
                        send(ACT_KEY_BYTE, rand_key_byte());
                    end
                    send(ACT_FINISH, 8'($urandom_range(0, 255)));
                end
            end
            send(ACT_END, 8'($urandom_range(0, 255)));
        end

        // Wait for the last letters, then let the block settle before judging.
        drain();
        repeat (SETTLE_CYCLES) @(posedge clk);
        @(negedge clk);
        if (sb.errors == 0 && sb.pending() == 0)
        begin
            $display("*** PASSED ***");
        end
        else
        begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule

// ----- filelist.f -----
sv/pfde_pkg.sv
sv/pfde_ifs.sv
sv/pfde_ram.sv
sv/playfair_digraph_encrypt.sv
dv/pfde_tb_pkg.sv
dv/tb_playfair_digraph_encrypt.sv
